>>> rtl/pulse_width_line_transmitter_unit_assert.svh
// Assertion macros for the pulse-width line transmitter.
`ifndef PULSE_WIDTH_LINE_TRANSMITTER_UNIT_ASSERT_SVH
`define PULSE_WIDTH_LINE_TRANSMITTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PWLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwlt assertion failed");

// Next-cycle implication, checked out of reset.
`define PWLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwlt assertion failed");

`endif

>>> rtl/pwlt_pkg.sv
package pwlt_pkg;

  localparam int unsigned WordBits  = 16;
  localparam int unsigned TimerBits = 8;
  localparam int unsigned CfgBits   = 8;
  localparam int unsigned CountBits = $clog2(WordBits + 1);
  localparam int unsigned AddrBits  = 5;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned TimerMax  = (1 << TimerBits) - 1;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [CfgBits-1:0]   cfg_val_t;
  typedef logic [WordBits-1:0]  word_t;
  typedef logic [CountBits-1:0] count_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegOneLow  = 3'd0;
  localparam logic [2:0] RegOneHigh = 3'd1;
  localparam logic [2:0] RegZeroLow = 3'd2;
  localparam logic [2:0] RegZeroHi  = 3'd3;
  localparam logic [2:0] RegGap     = 3'd4;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhLow  = 4'b0010,
    PhHigh = 4'b0100,
    PhGap  = 4'b1000
  } phase_e;

  typedef struct packed {
    cfg_val_t one_low;
    cfg_val_t one_high;
    cfg_val_t zero_low;
    cfg_val_t zero_high;
    cfg_val_t gap;
  } timing_t;

  localparam timing_t TimingReset = '{
    one_low:   cfg_val_t'(2),
    one_high:  cfg_val_t'(5),
    zero_low:  cfg_val_t'(7),
    zero_high: cfg_val_t'(0),
    gap:       cfg_val_t'(3)
  };

  function automatic timer_t timer_sat(input cfg_val_t v);
    if (32'(v) > 32'(TimerMax)) begin
      return timer_t'(32'(TimerMax));
    end
    return timer_t'(v);
  endfunction

  function automatic timer_t at_least_one(input cfg_val_t v);
    if (v == '0) begin
      return timer_t'(1);
    end
    return timer_sat(v);
  endfunction

endpackage

>>> rtl/pulse_width_line_transmitter_unit.sv
// Pulse-width single-wire transmitter, line idles high. A send item loads a
// 16-bit word (taken only while idle) and each tick item advances time by one
// tick; bits go out LSB first as low pulse, high time and recovery gap, with
// the timings set through the APB registers. Every item yields one result
// (line level, busy, accepted) in the output register on the clock after it
// is accepted. One item per clock: the transmitter state updates in a single
// step, and input ready only drops while a result sits unread in the output
// register and out_ready_i is low.
module pulse_width_line_transmitter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [pwlt_pkg::WordBits-1:0]   word_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            line_level_o,
  output logic                            busy_res_o,
  output logic                            accepted_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pwlt_pkg::AddrBits-1:0]   paddr,
  input  logic [pwlt_pkg::DataBits-1:0]   pwdata,
  output logic [pwlt_pkg::DataBits-1:0]   prdata,
  output logic                            pready
);
  import pwlt_pkg::*;

  timing_t timing;

  phase_e phase_q, phase_d;
  timer_t ticks_q, ticks_d;
  word_t  shift_q, shift_d;
  count_t bits_q, bits_d;

  logic out_valid_q;
  logic line_level_q, busy_q, accepted_q;
  logic acc;
  logic accept;
  word_t  shifted;
  count_t bits_dec;

  pwlt_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timing_o (timing)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign shifted  = shift_q >> 1;
  assign bits_dec = (bits_q != '0) ? bits_q - count_t'(1) : '0;

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    acc     = 1'b0;
    if (kind_i) begin
      if (phase_q == PhIdle) begin
        shift_d = word_in_i;
        bits_d  = count_t'(WordBits);
        phase_d = PhLow;
        ticks_d = at_least_one(word_in_i[0] ? timing.one_low : timing.zero_low);
        acc     = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhIdle: ;
        PhLow: begin
          if (ticks_q > timer_t'(1)) begin
            ticks_d = ticks_q - timer_t'(1);
          end else if (timer_sat(shift_q[0] ? timing.one_high : timing.zero_high) == '0) begin
            // no high time: straight into the gap
            phase_d = PhGap;
            ticks_d = at_least_one(timing.gap);
          end else begin
            phase_d = PhHigh;
            ticks_d = timer_sat(shift_q[0] ? timing.one_high : timing.zero_high);
          end
        end
        PhHigh: begin
          if (ticks_q > timer_t'(1)) begin
            ticks_d = ticks_q - timer_t'(1);
          end else begin
            phase_d = PhGap;
            ticks_d = at_least_one(timing.gap);
          end
        end
        PhGap: begin
          if (ticks_q > timer_t'(1)) begin
            ticks_d = ticks_q - timer_t'(1);
          end else if (bits_dec == '0) begin
            phase_d = PhIdle;
            ticks_d = '0;
            shift_d = '0;
            bits_d  = '0;
          end else begin
            shift_d = shifted;
            bits_d  = bits_dec;
            phase_d = PhLow;
            ticks_d = at_least_one(shifted[0] ? timing.one_low : timing.zero_low);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= '0;
      shift_q <= '0;
      bits_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_level_q <= (phase_d != PhLow);
      busy_q       <= (phase_d != PhIdle);
      accepted_q   <= acc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = line_level_q;
  assign busy_res_o   = busy_q;
  assign accepted_o   = accepted_q;

`include "pulse_width_line_transmitter_unit_assert.svh"

  `PWLT_ASSERT_NOW(a_idle_clear, phase_q == PhIdle, bits_q == '0 && ticks_q == '0)
  `PWLT_ASSERT_NOW(a_busy_bits, phase_q != PhIdle, bits_q != '0 && ticks_q != '0)
  `PWLT_ASSERT_NOW(a_taken_busy, out_valid_q && accepted_q, busy_q)
  `PWLT_ASSERT_NEXT(a_send_low, accept && kind_i && phase_q == PhIdle, out_valid_q && accepted_q && !line_level_q)

endmodule

>>> rtl/pwlt_regs.sv
module pwlt_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pwlt_pkg::AddrBits-1:0]   paddr,
  input  logic [pwlt_pkg::DataBits-1:0]   pwdata,
  output logic [pwlt_pkg::DataBits-1:0]   prdata,
  output logic                            pready,
  output pwlt_pkg::timing_t               timing_o
);
  import pwlt_pkg::*;

  timing_t    timing_q;
  logic       wr_en;
  logic [2:0] idx;
  cfg_val_t   wval;
  cfg_val_t   rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrBits-1:2];
  assign wval   = pwdata[CfgBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= TimingReset;
    end else if (wr_en) begin
      unique case (idx)
        RegOneLow:  timing_q.one_low   <= wval;
        RegOneHigh: timing_q.one_high  <= wval;
        RegZeroLow: timing_q.zero_low  <= wval;
        RegZeroHi:  timing_q.zero_high <= wval;
        RegGap:     timing_q.gap       <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegOneLow:  rval = timing_q.one_low;
      RegOneHigh: rval = timing_q.one_high;
      RegZeroLow: rval = timing_q.zero_low;
      RegZeroHi:  rval = timing_q.zero_high;
      RegGap:     rval = timing_q.gap;
      default:    rval = '0;
    endcase
  end

  assign prdata   = DataBits'(rval);
  assign timing_o = timing_q;

endmodule

>>> dv/pwlt_line_checker.sv
package pwlt_item_pkg;

  localparam logic KindTick = 1'b0;
  localparam logic KindSend = 1'b1;

endpackage

module pwlt_line_checker
  import pwlt_pkg::*;
  import pwlt_item_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                kind_i,
  input  word_t               word_in_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                line_level_o,
  input  logic                busy_res_o,
  input  logic                accepted_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output int unsigned         fail_count,
  output int unsigned         pending_count,
  output int unsigned         work_count,
  output logic                tx_busy
);

  typedef struct packed {
    logic level;
    logic busy;
    logic taken;
  } line_status_t;

  // predicted transmitter state and timing registers
  timing_t     timing;
  word_t       shift_reg;
  int unsigned bits_left;
  phase_e      line_phase;
  int unsigned ticks_left;

  line_status_t status_q[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  effective;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (mismatches < 40) begin
      $display("tb: mismatch on %s in result %0d: got %0b, want %0b",
               what, results_seen, got, want);
    end
    mismatches++;
  endtask

  // timer width equals register width, so no saturation is needed here
  function automatic int unsigned min_one(input cfg_val_t v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic void start_low();
    line_phase = PhLow;
    ticks_left = min_one(shift_reg[0] ? timing.one_low : timing.zero_low);
  endfunction

  function automatic void start_gap();
    line_phase = PhGap;
    ticks_left = min_one(timing.gap);
  endfunction

  function automatic void advance_tick();
    cfg_val_t hi;
    if (line_phase == PhIdle) return;
    if (ticks_left > 1) begin
      ticks_left--;
      return;
    end
    case (line_phase)
      PhLow: begin
        hi = shift_reg[0] ? timing.one_high : timing.zero_high;
        if (hi == '0) begin
          start_gap();
        end else begin
          line_phase = PhHigh;
          ticks_left = int'(hi);
        end
      end
      PhHigh: start_gap();
      default: begin
        // end of a bit cell; the last one drops straight back to idle
        shift_reg = shift_reg >> 1;
        if (bits_left > 0) bits_left--;
        if (bits_left == 0) begin
          line_phase = PhIdle;
          ticks_left = 0;
          shift_reg  = '0;
        end else begin
          start_low();
        end
      end
    endcase
  endfunction

  function automatic line_status_t step_line(input logic kind, input word_t word);
    line_status_t res;
    res.taken = 1'b0;
    if (kind == KindSend) begin
      if (line_phase == PhIdle) begin
        shift_reg = word;
        bits_left = WordBits;
        start_low();
        res.taken = 1'b1;
        effective++;
      end
    end else begin
      if (line_phase != PhIdle) effective++;
      advance_tick();
    end
    res.level = (line_phase != PhLow);
    res.busy  = (line_phase != PhIdle);
    return res;
  endfunction

  function automatic void write_timing(input logic [AddrBits-1:0] addr,
                                       input logic [DataBits-1:0] data);
    case (addr[AddrBits-1:2])
      RegOneLow:  timing.one_low   = data[CfgBits-1:0];
      RegOneHigh: timing.one_high  = data[CfgBits-1:0];
      RegZeroLow: timing.zero_low  = data[CfgBits-1:0];
      RegZeroHi:  timing.zero_high = data[CfgBits-1:0];
      RegGap:     timing.gap       = data[CfgBits-1:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_status_t want;
    if (!rst_ni) begin
      timing.one_low   = 8'd2;
      timing.one_high  = 8'd5;
      timing.zero_low  = 8'd7;
      timing.zero_high = 8'd0;
      timing.gap       = 8'd3;
      shift_reg     = '0;
      bits_left     = 0;
      line_phase    = PhIdle;
      ticks_left    = 0;
      status_q.delete();
      mismatches    = 0;
      results_seen  = 0;
      effective     = 0;
      fail_count    <= 0;
      pending_count <= 0;
      work_count    <= 0;
      tx_busy       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) write_timing(paddr, pwdata);
      // a result leaves no earlier than the edge after its item, so pop first
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("out_valid", out_valid_o, 1'b0);
        end else begin
          want = status_q.pop_front();
          if (line_level_o !== want.level) report_mismatch("line_level", line_level_o, want.level);
          if (busy_res_o !== want.busy) report_mismatch("busy_res", busy_res_o, want.busy);
          if (accepted_o !== want.taken) report_mismatch("accepted", accepted_o, want.taken);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) status_q.push_back(step_line(kind_i, word_in_i));
      fail_count    <= mismatches;
      pending_count <= status_q.size();
      work_count    <= effective;
      tx_busy       <= (line_phase != PhIdle);
    end
  end

endmodule

>>> dv/tb_pulse_width_line_transmitter_unit.sv
module tb_pulse_width_line_transmitter_unit;

  import pwlt_pkg::*;
  import pwlt_item_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                kind_i      = KindTick;
  word_t               word_in_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                line_level_o;
  logic                busy_res_o;
  logic                accepted_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0] pwdata      = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned work_count;
  logic        tx_busy;
  int unsigned cycles = 0;
  bit          calm   = 1'b0;

  pulse_width_line_transmitter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .word_in_i    (word_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .busy_res_o   (busy_res_o),
    .accepted_o   (accepted_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  pwlt_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .word_in_i     (word_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_level_o  (line_level_o),
    .busy_res_o    (busy_res_o),
    .accepted_o    (accepted_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .work_count    (work_count),
    .tx_busy       (tx_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 27);
  end

  // returns at the edge where the item is taken
  task automatic push_item(input logic kind, input word_t word);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    word_in_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // tick until the word is out and every result is back
  task automatic drain_line();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tx_busy) push_item(KindTick, word_t'($urandom()));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0 || tx_busy) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input cfg_val_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataBits'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_timing(input cfg_val_t one_low, input cfg_val_t one_high,
                            input cfg_val_t zero_low, input cfg_val_t zero_high,
                            input cfg_val_t gap);
    drain_line();
    apb_write(RegOneLow, one_low);
    apb_write(RegOneHigh, one_high);
    apb_write(RegZeroLow, zero_low);
    apb_write(RegZeroHi, zero_high);
    apb_write(RegGap, gap);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // mostly a send when idle followed by ticks, with stray sends as noise
  task automatic run_traffic(input int unsigned target, input bit hold_midway);
    int unsigned start;
    start = work_count;
    while (work_count - start < target) begin
      if (hold_midway && (work_count - start >= target / 2)) begin
        hold_midway = 1'b0;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_count != 0) @(posedge clk_i);
      end
      if (!tx_busy && $urandom_range(99) < 70) begin
        push_item(KindSend, pick_word());
      end else if ($urandom_range(99) < 6) begin
        push_item(KindSend, pick_word());
      end else begin
        push_item(KindTick, word_t'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: idle tick, full word, send while busy
    push_item(KindTick, '0);
    push_item(KindSend, 16'hFFFF);
    push_item(KindSend, 16'h1234);
    drain_line();
    // zero low and gap stretch to one tick, zero high is skipped
    set_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(KindSend, 16'h0000);
    drain_line();
    push_item(KindSend, 16'h8001);
    drain_line();
    set_timing(8'd1, 8'd0, 8'd1, 8'd0, 8'd1);
    push_item(KindSend, 16'hA5A5);
    drain_line();

    calm = 1'b1;
    set_timing(cfg_val_t'($urandom_range(1, 6)), cfg_val_t'($urandom_range(0, 6)),
               cfg_val_t'($urandom_range(1, 6)), cfg_val_t'($urandom_range(0, 6)),
               cfg_val_t'($urandom_range(1, 6)));
    run_traffic(250, 1'b0);
    calm = 1'b0;
    // longest low and high times on a lone one bit, short zero cells
    set_timing(8'd255, 8'd255, 8'd1, 8'd0, 8'd1);
    push_item(KindSend, 16'h0001);
    drain_line();
    set_timing(cfg_val_t'($urandom_range(0, 4)), cfg_val_t'($urandom_range(0, 4)),
               cfg_val_t'($urandom_range(0, 4)), cfg_val_t'($urandom_range(0, 4)),
               cfg_val_t'($urandom_range(0, 4)));
    run_traffic(250, 1'b1);
    set_timing(cfg_val_t'($urandom_range(1, 9)), cfg_val_t'($urandom_range(0, 9)),
               cfg_val_t'($urandom_range(1, 9)), cfg_val_t'($urandom_range(0, 9)),
               cfg_val_t'($urandom_range(1, 9)));
    run_traffic(250, 1'b0);

    drain_line();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> pulse_width_line_transmitter_unit.f
+incdir+rtl
rtl/pwlt_pkg.sv
rtl/pwlt_regs.sv
rtl/pulse_width_line_transmitter_unit.sv
dv/pwlt_line_checker.sv
dv/tb_pulse_width_line_transmitter_unit.sv
